/* hdl/nrmc_pkg.sv */
// shared types, constants and helper functions of the rmc position parser
`timescale 1ns / 1ps
`default_nettype none

package nrmc_pkg;

    // packet and number format
    localparam int MAX_PACKET_BYTES = 1024 * 3;
    localparam int FRACTION_DIGITS  = 4;
    localparam int BYTE_CNT_W       = $clog2(MAX_PACKET_BYTES + 2);
    localparam int FRAC_W           = $clog2(FRACTION_DIGITS + 1);
    localparam int SCALE_W          = $clog2(10 ** FRACTION_DIGITS + 1);
    localparam int ACC_W            = 30;
    localparam int FIELD_W          = 4;
    localparam int HDR_LEN          = 6;
    localparam int HDR_W            = 3;

    localparam logic [ACC_W-1:0]   VALUE_LIMIT = ACC_W'(999999999);
    localparam logic [FIELD_W-1:0] FIELD_MAX   = '1;
    localparam logic [FIELD_W-1:0] FIELD_STATUS = FIELD_W'(2);
    localparam logic [FIELD_W-1:0] FIELD_LAT    = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] FIELD_LON    = FIELD_W'(5);

    // characters of interest
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    // running checksum right after the header (the '$' is not included)
    localparam logic [7:0] HEADER_XOR = CH_G ^ CH_N ^ CH_R ^ CH_M ^ CH_C;

    // result codes
    typedef enum logic [1:0] {
        FIX_NONE  = 2'd0,
        FIX_VOID  = 2'd1,
        FIX_VALID = 2'd2
    } fix_event_t;

    // one input character
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_end;
    } in_item_t;

    // one report
    typedef struct packed {
        logic             valid;
        fix_event_t       fix_event;
        logic [7:0]       status_char;
        logic [ACC_W-1:0] latitude_e4;
        logic [ACC_W-1:0] longitude_e4;
    } result_t;

    // expected character at each header position
    function automatic logic [7:0] header_char(input logic [HDR_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            HDR_W'(0): c = CH_DOLLAR;
            HDR_W'(1): c = CH_G;
            HDR_W'(2): c = CH_N;
            HDR_W'(3): c = CH_R;
            HDR_W'(4): c = CH_M;
            HDR_W'(5): c = CH_C;
            default:   c = CH_DOLLAR;
        endcase
        return c;
    endfunction

    // v * 10 + d, saturated at the value limit
    function automatic logic [ACC_W-1:0] sat_mul_add(input logic [ACC_W-1:0] v,
                                                     input logic [3:0] d);
        logic [ACC_W+3:0] r;
        r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{ACC_W{1'b0}}, d};
        return (r > {4'b0, VALUE_LIMIT}) ? VALUE_LIMIT : r[ACC_W-1:0];
    endfunction

    // power of ten for the fraction digits still missing
    function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_W-1:0] cnt);
        logic [SCALE_W-1:0] s;
        s = SCALE_W'(1);
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (i >= int'(cnt))
                s = SCALE_W'(s * SCALE_W'(10));
        end
        return s;
    endfunction

    // number scaled to the fixed point, saturated at the value limit
    function automatic logic [ACC_W-1:0] scale_number(input logic [ACC_W-1:0] v,
                                                      input logic [FRAC_W-1:0] cnt);
        logic [ACC_W+SCALE_W-1:0] p;
        p = {{SCALE_W{1'b0}}, v} * {{ACC_W{1'b0}}, frac_scale(cnt)};
        return (p > {{SCALE_W{1'b0}}, VALUE_LIMIT}) ? VALUE_LIMIT : p[ACC_W-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_upper_hex(input logic [7:0] b);
        return (b >= CH_A) && (b <= CH_F);
    endfunction

endpackage

`default_nettype wire

/* hdl/nrmc_input_reg.sv */
// input holding register of the rmc position parser
`timescale 1ns / 1ps
`default_nettype none

module nrmc_input_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire nrmc_pkg::in_item_t in_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output nrmc_pkg::in_item_t     item
);

    logic               valid_reg;
    logic               valid_next;
    nrmc_pkg::in_item_t item_reg;
    logic               accept;

    // hold a request only while the parse stage cannot take the held one
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (valid_reg && advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* hdl/nrmc_parse_core.sv */
// sentence state machine, checksum and number parsing of the rmc parser
`timescale 1ns / 1ps
`default_nettype none

module nrmc_parse_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire nrmc_pkg::in_item_t item,
    output nrmc_pkg::result_t       res
);

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_BODY    = 3'd1,
        PH_CHECK   = 3'd2,
        PH_WAIT_LF = 3'd3,
        PH_GOOD    = 3'd4,
        PH_FAIL    = 3'd5
    } phase_t;

    phase_t                          phase_reg,    phase_next;
    logic [nrmc_pkg::HDR_W-1:0]      hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]                      xor_reg,      xor_next;
    logic [7:0]                      chk_reg,      chk_next;
    logic [1:0]                      chk_cnt_reg,  chk_cnt_next;
    logic [nrmc_pkg::FIELD_W-1:0]    field_reg,    field_next;
    logic [nrmc_pkg::ACC_W-1:0]      num_reg,      num_next;
    logic [nrmc_pkg::FRAC_W-1:0]     frac_reg,     frac_next;
    logic                            dot_reg,      dot_next;
    logic                            stop_reg,     stop_next;
    logic                            taken_reg,    taken_next;
    logic [nrmc_pkg::ACC_W-1:0]      pend_lat_reg, pend_lat_next;
    logic [nrmc_pkg::ACC_W-1:0]      pend_lon_reg, pend_lon_next;
    logic [7:0]                      pend_st_reg,  pend_st_next;
    logic [nrmc_pkg::ACC_W-1:0]      lat_reg,      lat_next;
    logic [nrmc_pkg::ACC_W-1:0]      lon_reg,      lon_next;
    logic [7:0]                      st_reg,       st_next;
    logic [nrmc_pkg::BYTE_CNT_W-1:0] bcnt_reg,     bcnt_next;

    logic [7:0]                   b;
    logic [nrmc_pkg::ACC_W-1:0]   scaled;
    logic [nrmc_pkg::ACC_W-1:0]   digit_acc;
    logic [3:0]                   hex_nib;
    logic                         hex_ok;
    logic                         oversize;
    logic                         good;
    logic                         fix_a;
    nrmc_pkg::result_t            res_next;

    assign b = item.rx_byte;

    // field value when it closes, and value with this digit appended
    assign scaled    = nrmc_pkg::scale_number(num_reg, frac_reg);
    assign digit_acc = nrmc_pkg::sat_mul_add(num_reg, b[3:0]);

    // checksum digit decode
    assign hex_ok  = nrmc_pkg::is_digit(b) || nrmc_pkg::is_upper_hex(b);
    assign hex_nib = nrmc_pkg::is_digit(b) ? b[3:0] : 4'(b[3:0] + 4'd9);

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        xor_next      = xor_reg;
        chk_next      = chk_reg;
        chk_cnt_next  = chk_cnt_reg;
        field_next    = field_reg;
        num_next      = num_reg;
        frac_next     = frac_reg;
        dot_next      = dot_reg;
        stop_next     = stop_reg;
        taken_next    = taken_reg;
        pend_lat_next = pend_lat_reg;
        pend_lon_next = pend_lon_reg;
        pend_st_next  = pend_st_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        st_next       = st_reg;
        res_next      = '0;

        // byte count saturates one past the limit
        if (bcnt_reg <= nrmc_pkg::BYTE_CNT_W'(nrmc_pkg::MAX_PACKET_BYTES))
            bcnt_next = bcnt_reg + 1'b1;
        else
            bcnt_next = bcnt_reg;

        unique case (phase_reg)
            // header search, a stray '$' restarts the match
            PH_SEARCH:
            begin
                if (b == nrmc_pkg::header_char(hdr_cnt_reg)) begin
                    hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    if (hdr_cnt_reg == nrmc_pkg::HDR_W'(nrmc_pkg::HDR_LEN - 1)) begin
                        phase_next    = PH_BODY;
                        xor_next      = nrmc_pkg::HEADER_XOR;
                        field_next    = '0;
                        num_next      = '0;
                        frac_next     = '0;
                        dot_next      = 1'b0;
                        stop_next     = 1'b0;
                        taken_next    = 1'b0;
                        pend_st_next  = st_reg;
                        pend_lat_next = '0;
                        pend_lon_next = '0;
                    end
                end else begin
                    hdr_cnt_next = (b == nrmc_pkg::CH_DOLLAR) ? nrmc_pkg::HDR_W'(1) : '0;
                end
            end
            // sentence body up to the '*'
            PH_BODY:
            begin
                if (b == nrmc_pkg::CH_STAR) begin
                    if (field_reg == nrmc_pkg::FIELD_LAT)
                        pend_lat_next = scaled;
                    else if (field_reg == nrmc_pkg::FIELD_LON)
                        pend_lon_next = scaled;
                    phase_next   = PH_CHECK;
                    chk_next     = '0;
                    chk_cnt_next = '0;
                end else if (b == nrmc_pkg::CH_CR || b == nrmc_pkg::CH_LF) begin
                    phase_next = PH_FAIL;
                end else begin
                    xor_next = xor_reg ^ b;
                    if (b == nrmc_pkg::CH_COMMA) begin
                        if (field_reg == nrmc_pkg::FIELD_LAT)
                            pend_lat_next = scaled;
                        else if (field_reg == nrmc_pkg::FIELD_LON)
                            pend_lon_next = scaled;
                        if (field_reg < nrmc_pkg::FIELD_MAX)
                            field_next = field_reg + 1'b1;
                        num_next  = '0;
                        frac_next = '0;
                        dot_next  = 1'b0;
                        stop_next = 1'b0;
                    end else if (field_reg == nrmc_pkg::FIELD_STATUS) begin
                        if (!taken_reg) begin
                            pend_st_next = b;
                            taken_next   = 1'b1;
                        end
                    end else if ((field_reg == nrmc_pkg::FIELD_LAT ||
                                  field_reg == nrmc_pkg::FIELD_LON) && !stop_reg) begin
                        if (nrmc_pkg::is_digit(b)) begin
                            if (!dot_reg) begin
                                num_next = digit_acc;
                            end else if (frac_reg <
                                         nrmc_pkg::FRAC_W'(nrmc_pkg::FRACTION_DIGITS)) begin
                                num_next  = digit_acc;
                                frac_next = frac_reg + 1'b1;
                            end
                        end else if (b == nrmc_pkg::CH_DOT && !dot_reg) begin
                            dot_next = 1'b1;
                        end else begin
                            stop_next = 1'b1;
                        end
                    end
                end
            end
            // checksum digits and the closing cr lf
            PH_CHECK, PH_WAIT_LF:
            begin
                if (phase_reg == PH_WAIT_LF && b == nrmc_pkg::CH_LF) begin
                    phase_next = (chk_cnt_reg == 2'd2 && chk_reg == xor_reg) ?
                                 PH_GOOD : PH_FAIL;
                end else if (b == nrmc_pkg::CH_CR) begin
                    if (phase_reg == PH_WAIT_LF)
                        chk_cnt_next = '0;
                    phase_next = PH_WAIT_LF;
                end else begin
                    phase_next = PH_CHECK;
                    if (hex_ok) begin
                        chk_next = {chk_reg[3:0], hex_nib};
                        if (phase_reg == PH_WAIT_LF)
                            chk_cnt_next = 2'd1;
                        else if (chk_cnt_reg < 2'd2)
                            chk_cnt_next = chk_cnt_reg + 1'b1;
                    end else begin
                        chk_cnt_next = '0;
                    end
                end
            end
            // rest of the packet is ignored
            PH_GOOD, PH_FAIL:
            begin
            end
            default:
            begin
            end
        endcase

        // packet end: report unless oversize or a broken sentence, update stored values, clear the sentence state
        if (item.packet_end) begin
            oversize = bcnt_next > nrmc_pkg::BYTE_CNT_W'(nrmc_pkg::MAX_PACKET_BYTES);
            good     = phase_next == PH_GOOD;
            fix_a    = pend_st_reg == nrmc_pkg::CH_A;
            if (!oversize && (good || phase_next == PH_SEARCH)) begin
                if (good) begin
                    st_next = pend_st_reg;
                    if (fix_a && pend_lat_reg != '0)
                        lat_next = pend_lat_reg;
                    if (fix_a && pend_lon_reg != '0)
                        lon_next = pend_lon_reg;
                end
                res_next.valid        = 1'b1;
                res_next.fix_event    = !good ? nrmc_pkg::FIX_NONE :
                                        fix_a ? nrmc_pkg::FIX_VALID : nrmc_pkg::FIX_VOID;
                res_next.status_char  = st_next;
                res_next.latitude_e4  = lat_next;
                res_next.longitude_e4 = lon_next;
            end
            phase_next    = PH_SEARCH;
            hdr_cnt_next  = '0;
            xor_next      = '0;
            chk_next      = '0;
            chk_cnt_next  = '0;
            field_next    = '0;
            num_next      = '0;
            frac_next     = '0;
            dot_next      = 1'b0;
            stop_next     = 1'b0;
            taken_next    = 1'b0;
            pend_lat_next = '0;
            pend_lon_next = '0;
            pend_st_next  = '0;
            bcnt_next     = '0;
        end else begin
            oversize = 1'b0;
            good     = 1'b0;
            fix_a    = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_SEARCH;
            hdr_cnt_reg  <= '0;
            xor_reg      <= '0;
            chk_reg      <= '0;
            chk_cnt_reg  <= '0;
            field_reg    <= '0;
            num_reg      <= '0;
            frac_reg     <= '0;
            dot_reg      <= 1'b0;
            stop_reg     <= 1'b0;
            taken_reg    <= 1'b0;
            pend_lat_reg <= '0;
            pend_lon_reg <= '0;
            pend_st_reg  <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            st_reg       <= '0;
            bcnt_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            xor_reg      <= xor_next;
            chk_reg      <= chk_next;
            chk_cnt_reg  <= chk_cnt_next;
            field_reg    <= field_next;
            num_reg      <= num_next;
            frac_reg     <= frac_next;
            dot_reg      <= dot_next;
            stop_reg     <= stop_next;
            taken_reg    <= taken_next;
            pend_lat_reg <= pend_lat_next;
            pend_lon_reg <= pend_lon_next;
            pend_st_reg  <= pend_st_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            st_reg       <= st_next;
            bcnt_reg     <= bcnt_next;
        end
    end

    assign res = res_next;

endmodule

`default_nettype wire

/* hdl/nrmc_result_reg.sv */
// output register of the rmc position parser
`timescale 1ns / 1ps
`default_nettype none

module nrmc_result_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire nrmc_pkg::result_t res,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             fix_event,
    output logic [7:0]             status_char,
    output logic [29:0]            latitude_e4,
    output logic [29:0]            longitude_e4
);

    logic              valid_reg;
    logic              valid_next;
    nrmc_pkg::result_t data_reg;

    // a held request stays until taken, a new one only arrives into a free slot
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid    = valid_reg;
    assign fix_event    = data_reg.fix_event;
    assign status_char  = data_reg.status_char;
    assign latitude_e4  = data_reg.latitude_e4;
    assign longitude_e4 = data_reg.longitude_e4;

endmodule

`default_nettype wire

/* hdl/nmea_rmc_position_parser.sv */
// top level of the rmc position parser
// an accepted character is held in the input register and then parsed, and the report it
//   closes is loaded into the output register, which drives the output ports
// throughput: one character per cycle; the only hold-up is a last character
//   arriving while the one-entry output register still holds a stalled report
// reset: asynchronous, active low; clears sentence state, stored position and status
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_position_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        packet_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       fix_event,
    output logic [7:0]       status_char,
    output logic [29:0]      latitude_e4,
    output logic [29:0]      longitude_e4
);

    nrmc_pkg::in_item_t in_item;
    nrmc_pkg::in_item_t item;
    nrmc_pkg::result_t  res;
    logic               item_valid;
    logic               advance;
    logic               step;

    assign in_item.rx_byte    = rx_byte;
    assign in_item.packet_end = packet_end;

    // a last character waits only while the output slot is full and stalled
    assign advance = !(item.packet_end && out_valid && out_stall);
    assign step    = item_valid && advance;

    nrmc_input_reg u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nrmc_parse_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .res   (res)
    );

    nrmc_result_reg u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && res.valid),
        .res          (res),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fix_event    (fix_event),
        .status_char  (status_char),
        .latitude_e4  (latitude_e4),
        .longitude_e4 (longitude_e4)
    );

endmodule

`default_nettype wire

/* hdl/nrmc_checker.sv */
// port-level checks of the rmc position parser, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module nrmc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        packet_end,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  fix_event,
    input  wire logic [7:0]  status_char,
    input  wire logic [29:0] latitude_e4,
    input  wire logic [29:0] longitude_e4
);

    // no report while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("report shown during reset");

    // a stalled report holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({fix_event, status_char, latitude_e4, longitude_e4}))
        else $error("stalled report changed");

    // a new report follows an accepted last-character request
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && packet_end, 2))
        else $error("report without a packet end");

    // only the three defined result codes appear
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fix_event == nrmc_pkg::FIX_NONE ||
                       fix_event == nrmc_pkg::FIX_VOID ||
                       fix_event == nrmc_pkg::FIX_VALID))
        else $error("undefined result code");

endmodule

bind nmea_rmc_position_parser nrmc_checker u_nrmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .packet_end   (packet_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fix_event    (fix_event),
    .status_char  (status_char),
    .latitude_e4  (latitude_e4),
    .longitude_e4 (longitude_e4)
);

`default_nettype wire

/* bench/nrmc_position_checker.sv */
// checker for the rmc position parser: follows both channels, predicts each report and compares it
`timescale 1ns / 1ps
`default_nettype none

module nrmc_position_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        packet_end,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  fix_event,
    input  wire logic [7:0]  status_char,
    input  wire logic [29:0] latitude_e4,
    input  wire logic [29:0] longitude_e4,
    output int               fail_count,
    output int               reports_waiting
);

    // where the parser stands within one packet
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_BODY,
        PH_CHECK,
        PH_WAIT_LF,
        PH_GOOD,
        PH_FAIL
    } rmc_phase_t;

    typedef struct packed {
        nrmc_pkg::fix_event_t ev;
        logic [7:0]           status;
        logic [29:0]          lat;
        logic [29:0]          lon;
    } rmc_report_t;

    localparam logic [47:0] RMC_HEADER    = {nrmc_pkg::CH_DOLLAR, nrmc_pkg::CH_G,
                                             nrmc_pkg::CH_N, nrmc_pkg::CH_R,
                                             nrmc_pkg::CH_M, nrmc_pkg::CH_C};
    localparam logic [7:0]  STATUS_ACTIVE = nrmc_pkg::CH_A;

    rmc_report_t report_q[$];

    // sentence state
    rmc_phase_t  phase;
    int unsigned hdr_pos;
    logic [7:0]  run_xor;
    logic [7:0]  sum_digits;
    int unsigned sum_digit_cnt;
    int unsigned field_idx;
    logic [29:0] num_acc;
    int unsigned frac_cnt;
    bit          dot_seen;
    bit          num_done;
    bit          status_seen;
    logic [29:0] lat_pending;
    logic [29:0] lon_pending;
    logic [7:0]  status_pending;
    int unsigned byte_count;

    // values kept across packets
    logic [29:0] lat_kept;
    logic [29:0] lon_kept;
    logic [7:0]  status_kept;

    initial
    begin
        fail_count      = 0;
        reports_waiting = 0;
    end

    // v * 10 + d, held at the value limit
    function automatic logic [29:0] shift_in_digit(input logic [29:0] v, input int unsigned d);
        longint unsigned r;
        r = 64'(v) * 64'd10 + 64'(d);
        if (r > 64'(nrmc_pkg::VALUE_LIMIT))
            return nrmc_pkg::VALUE_LIMIT;
        return r[29:0];
    endfunction

    function void restart_number();
        num_acc  = '0;
        frac_cnt = 0;
        dot_seen = 1'b0;
        num_done = 1'b0;
    endfunction

    // scale the number read so far and latch it for its field
    function void close_field();
        logic [29:0] v;
        v = num_acc;
        for (int unsigned i = frac_cnt; i < nrmc_pkg::FRACTION_DIGITS; i++)
            v = shift_in_digit(v, 0);
        if (field_idx == nrmc_pkg::FIELD_LAT)
            lat_pending = v;
        else if (field_idx == nrmc_pkg::FIELD_LON)
            lon_pending = v;
    endfunction

    function void drop_packet_state();
        phase          = PH_SEARCH;
        hdr_pos        = 0;
        run_xor        = '0;
        sum_digits     = '0;
        sum_digit_cnt  = 0;
        field_idx      = 0;
        restart_number();
        status_seen    = 1'b0;
        lat_pending    = '0;
        lon_pending    = '0;
        status_pending = '0;
        byte_count     = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rmc_report_t want;
        logic [3:0]  nib;
        bit          is_hex;
        if (!rst_n)
        begin
            report_q.delete();
            status_kept = '0;
            lat_kept    = '0;
            lon_kept    = '0;
            drop_packet_state();
        end
        else
        begin
            // compare each accepted report with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report with none outstanding: fix_event %0d status_char %h",
                           fix_event, status_char);
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (fix_event !== want.ev)
                    begin
                        $error("fix_event: expected %0d, got %0d", want.ev, fix_event);
                        fail_count++;
                    end
                    if (status_char !== want.status)
                    begin
                        $error("status_char: expected %h, got %h", want.status, status_char);
                        fail_count++;
                    end
                    if (latitude_e4 !== want.lat)
                    begin
                        $error("latitude_e4: expected %0d, got %0d", want.lat, latitude_e4);
                        fail_count++;
                    end
                    if (longitude_e4 !== want.lon)
                    begin
                        $error("longitude_e4: expected %0d, got %0d", want.lon, longitude_e4);
                        fail_count++;
                    end
                end
            end

            // follow the parser on each accepted request
            if (in_valid && !in_stall)
            begin
                if (byte_count <= nrmc_pkg::MAX_PACKET_BYTES)
                    byte_count++;

                case (phase)
                    // hunt for the header, a stray dollar restarts the match
                    PH_SEARCH:
                        if (rx_byte == RMC_HEADER[47 - 8 * hdr_pos -: 8])
                        begin
                            hdr_pos++;
                            if (hdr_pos >= nrmc_pkg::HDR_LEN)
                            begin
                                phase          = PH_BODY;
                                run_xor        = nrmc_pkg::HEADER_XOR;
                                field_idx      = 0;
                                restart_number();
                                status_seen    = 1'b0;
                                status_pending = status_kept;
                                lat_pending    = '0;
                                lon_pending    = '0;
                            end
                        end
                        else
                            hdr_pos = (rx_byte == nrmc_pkg::CH_DOLLAR) ? 1 : 0;

                    // sentence body up to the star
                    PH_BODY:
                        if (rx_byte == nrmc_pkg::CH_STAR)
                        begin
                            close_field();
                            phase         = PH_CHECK;
                            sum_digits    = '0;
                            sum_digit_cnt = 0;
                        end
                        else if (rx_byte == nrmc_pkg::CH_CR || rx_byte == nrmc_pkg::CH_LF)
                            phase = PH_FAIL;
                        else
                        begin
                            run_xor ^= rx_byte;
                            if (rx_byte == nrmc_pkg::CH_COMMA)
                            begin
                                close_field();
                                if (field_idx < nrmc_pkg::FIELD_MAX)
                                    field_idx++;
                                restart_number();
                            end
                            else if (field_idx == nrmc_pkg::FIELD_STATUS)
                            begin
                                if (!status_seen)
                                begin
                                    status_pending = rx_byte;
                                    status_seen    = 1'b1;
                                end
                            end
                            else if ((field_idx == nrmc_pkg::FIELD_LAT ||
                                      field_idx == nrmc_pkg::FIELD_LON) && !num_done)
                            begin
                                if (rx_byte >= nrmc_pkg::CH_ZERO && rx_byte <= nrmc_pkg::CH_NINE)
                                begin
                                    if (!dot_seen)
                                        num_acc = shift_in_digit(num_acc,
                                                                 rx_byte - nrmc_pkg::CH_ZERO);
                                    else if (frac_cnt < nrmc_pkg::FRACTION_DIGITS)
                                    begin
                                        num_acc = shift_in_digit(num_acc,
                                                                 rx_byte - nrmc_pkg::CH_ZERO);
                                        frac_cnt++;
                                    end
                                end
                                else if (rx_byte == nrmc_pkg::CH_DOT && !dot_seen)
                                    dot_seen = 1'b1;
                                else
                                    num_done = 1'b1;
                            end
                        end

                    // checksum digits and the closing cr lf
                    PH_CHECK, PH_WAIT_LF:
                        if (phase == PH_WAIT_LF && rx_byte == nrmc_pkg::CH_LF)
                            phase = (sum_digit_cnt == 2 && sum_digits == run_xor)
                                    ? PH_GOOD : PH_FAIL;
                        else
                        begin
                            // a cr not followed by lf spoils the digits seen so far
                            if (phase == PH_WAIT_LF)
                                sum_digit_cnt = 0;
                            if (rx_byte == nrmc_pkg::CH_CR)
                                phase = PH_WAIT_LF;
                            else
                            begin
                                phase  = PH_CHECK;
                                is_hex = 1'b1;
                                nib    = '0;
                                if (rx_byte >= nrmc_pkg::CH_ZERO && rx_byte <= nrmc_pkg::CH_NINE)
                                    nib = rx_byte[3:0];
                                else if (rx_byte >= nrmc_pkg::CH_A && rx_byte <= nrmc_pkg::CH_F)
                                    nib = rx_byte[3:0] + 4'd9;
                                else
                                    is_hex = 1'b0;
                                if (!is_hex)
                                    sum_digit_cnt = 0;
                                else
                                begin
                                    sum_digits = {sum_digits[3:0], nib};
                                    if (sum_digit_cnt < 2)
                                        sum_digit_cnt++;
                                end
                            end
                        end

                    default: ;
                endcase

                // end of packet: report unless oversize or a broken sentence
                if (packet_end)
                begin
                    if (byte_count <= nrmc_pkg::MAX_PACKET_BYTES &&
                        (phase == PH_SEARCH || phase == PH_GOOD))
                    begin
                        if (phase == PH_SEARCH)
                            want.ev = nrmc_pkg::FIX_NONE;
                        else
                        begin
                            status_kept = status_pending;
                            if (status_pending == STATUS_ACTIVE)
                            begin
                                if (lat_pending != 0)
                                    lat_kept = lat_pending;
                                if (lon_pending != 0)
                                    lon_kept = lon_pending;
                                want.ev = nrmc_pkg::FIX_VALID;
                            end
                            else
                                want.ev = nrmc_pkg::FIX_VOID;
                        end
                        want.status = status_kept;
                        want.lat    = lat_kept;
                        want.lon    = lon_kept;
                        report_q.push_back(want);
                    end
                    drop_packet_state();
                end
            end
        end
        reports_waiting = report_q.size();
    end

endmodule

`default_nettype wire

/* bench/tb_nmea_rmc_position_parser.sv */
// testbench top for the rmc position parser: packet stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_nmea_rmc_position_parser;

    // how a sentence is closed after its body
    typedef enum int {
        SUM_GOOD,
        SUM_WRONG,
        SUM_LOWER,
        SUM_ONE_DIGIT,
        SUM_THREE_DIGITS,
        SUM_CR_ALONE,
        SUM_DOUBLE_CR,
        SUM_NO_END,
        SUM_CR_IN_BODY
    } sum_tail_t;

    // receiver behaviour
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    localparam int RANDOM_BYTES = 1200;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte    = '0;
    logic        packet_end = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  fix_event;
    logic [7:0]  status_char;
    logic [29:0] latitude_e4;
    logic [29:0] longitude_e4;

    int          fail_count;
    int          reports_waiting;

    logic [7:0]  pkt_q[$];
    int          sentence_start = 0;
    int          burst_left     = 0;
    int          bytes_sent     = 0;
    int          stall_tick     = 0;
    rx_mode_t    rx_mode        = RX_FREE;

    nmea_rmc_position_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .packet_end   (packet_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fix_event    (fix_event),
        .status_char  (status_char),
        .latitude_e4  (latitude_e4),
        .longitude_e4 (longitude_e4)
    );

    nrmc_position_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .packet_end      (packet_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fix_event       (fix_event),
        .status_char     (status_char),
        .latitude_e4     (latitude_e4),
        .longitude_e4    (longitude_e4),
        .fail_count      (fail_count),
        .reports_waiting (reports_waiting)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stalls, switching pattern every so often
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
            rx_mode = rx_mode_t'($urandom_range(RX_FREE, RX_PERIODIC));
        case (rx_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= stall_tick[2];
        endcase
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pkt_q.push_back(s[i]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) pkt_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_digits(input int n);
        repeat (n) pkt_q.push_back(nrmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // any character that keeps the sentence body going
    task automatic put_body_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == nrmc_pkg::CH_STAR || c == nrmc_pkg::CH_CR || c == nrmc_pkg::CH_LF);
        pkt_q.push_back(c);
    endtask

    task automatic open_rmc();
        sentence_start = pkt_q.size();
        put_text("$GNRMC");
    endtask

    // star, checksum and line end, spoilt as asked
    task automatic close_rmc(input sum_tail_t tail);
        string      digits;
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = sentence_start + 1; i < pkt_q.size(); i++)
            sum ^= pkt_q[i];
        if (tail == SUM_CR_IN_BODY)
            pkt_q.push_back(nrmc_pkg::CH_CR);
        if (tail == SUM_WRONG)
            sum ^= 8'(1 << $urandom_range(0, 7));
        digits = (tail == SUM_LOWER) ? "0123456789abcdef" : "0123456789ABCDEF";
        pkt_q.push_back(nrmc_pkg::CH_STAR);
        if (tail == SUM_THREE_DIGITS)
            pkt_q.push_back(digits[$urandom_range(0, 15)]);
        if (tail != SUM_ONE_DIGIT)
            pkt_q.push_back(digits[sum[7:4]]);
        pkt_q.push_back(digits[sum[3:0]]);
        case (tail)
            SUM_NO_END:    ;
            SUM_CR_ALONE:  put_text("\r#\r\n");
            SUM_DOUBLE_CR: put_text("\r\r\n");
            default:       put_text("\r\n");
        endcase
    endtask

    // coordinate text: mostly well formed, sometimes empty, huge or cut short
    task automatic put_number();
        case ($urandom_range(0, 9))
            0: ;
            1: put_text("0000.0000");
            2:
            begin
                put_digits($urandom_range(9, 12));
                pkt_q.push_back(nrmc_pkg::CH_DOT);
                put_digits($urandom_range(0, 6));
            end
            3:
            begin
                pkt_q.push_back($urandom_range(0, 1) ? "-" : "+");
                put_digits($urandom_range(1, 4));
            end
            4:
            begin
                put_digits($urandom_range(0, 4));
                pkt_q.push_back(nrmc_pkg::CH_DOT);
                put_digits($urandom_range(0, 3));
                pkt_q.push_back($urandom_range(0, 1) ? nrmc_pkg::CH_DOT : "x");
                put_digits($urandom_range(0, 3));
            end
            default:
            begin
                put_digits($urandom_range(1, 5));
                if ($urandom_range(0, 4) != 0)
                begin
                    pkt_q.push_back(nrmc_pkg::CH_DOT);
                    put_digits($urandom_range(0, 7));
                end
            end
        endcase
    endtask

    // rmc fields with random content
    task automatic put_random_fields();
        pkt_q.push_back(nrmc_pkg::CH_COMMA);
        if ($urandom_range(0, 1))
            put_digits(6);
        pkt_q.push_back(nrmc_pkg::CH_COMMA);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pkt_q.push_back(nrmc_pkg::CH_A);
            6, 7:             pkt_q.push_back("V");
            8:                ;
            default:          repeat ($urandom_range(1, 2)) put_body_byte();
        endcase
        pkt_q.push_back(nrmc_pkg::CH_COMMA);
        put_number();
        put_text(",N,");
        put_number();
        put_text(",E");
        repeat ($urandom_range(0, 3))
        begin
            pkt_q.push_back(nrmc_pkg::CH_COMMA);
            repeat ($urandom_range(0, 3)) put_body_byte();
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 14)) pkt_q.push_back(nrmc_pkg::CH_COMMA);
    endtask

    task automatic build_random_packet();
        int kind;
        kind = $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0)
            put_noise($urandom_range(1, 6));
        if (kind < 14)
        begin
            open_rmc();
            put_random_fields();
            close_rmc(SUM_GOOD);
        end
        else if (kind < 16)
        begin
            open_rmc();
            put_random_fields();
            close_rmc(sum_tail_t'($urandom_range(SUM_WRONG, SUM_CR_IN_BODY)));
        end
        else if (kind < 18)
            put_noise($urandom_range(1, 12));
        else
        begin
            // near misses of the header
            case ($urandom_range(0, 2))
                0: put_text("$GPRMC,,A,1234.5,N,1,E*00\r\n");
                1: put_text("$GNRM$");
                default:
                begin
                    put_text("$$GN");
                    open_rmc();
                    put_random_fields();
                    close_rmc(SUM_GOOD);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            put_noise($urandom_range(1, 4));
    endtask

    // send the packet in bursts, holding each request until it is taken
    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                         : $urandom_range(1, 12);
            end
            in_valid   <= 1'b1;
            rx_byte    <= pkt_q[i];
            packet_end <= (i == pkt_q.size() - 1);
            @(negedge clk);
            while (in_stall)
                @(negedge clk);
            @(posedge clk);
            burst_left--;
        end
        bytes_sent += pkt_q.size();
        pkt_q.delete();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single byte, no sentence
        pkt_q.push_back(8'h00);
        send_packet();

        // header at the very start, active fix
        open_rmc();
        put_text(",123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
        close_rmc(SUM_GOOD);
        send_packet();

        // empty status keeps the previous letter, empty longitude keeps its value
        open_rmc();
        put_text(",,,3000.5,S,,W");
        close_rmc(SUM_GOOD);
        send_packet();

        // void data leaves the position alone
        open_rmc();
        put_text(",,V,1111.1111,N,02222.2222,E");
        close_rmc(SUM_GOOD);
        send_packet();

        // saturation and cut-off of extra fraction digits
        open_rmc();
        put_text(",1,A,99999999999.99999,N,9999.99999,E");
        close_rmc(SUM_GOOD);
        send_packet();

        // zero and empty positions are never stored
        open_rmc();
        put_text(",1,A,0000.0000,N,,E");
        close_rmc(SUM_GOOD);
        send_packet();

        // signs and a second dot end the number
        open_rmc();
        put_text(",1,A,-12.5,N,12-5,E");
        close_rmc(SUM_GOOD);
        send_packet();
        open_rmc();
        put_text(",1,A,12.3.4,N,+7,E");
        close_rmc(SUM_GOOD);
        send_packet();

        // noise and false starts before the header, a later sentence ignored
        pkt_q.push_back(8'hFF);
        pkt_q.push_back(8'h80);
        put_text("$GN$GPRMC,$$GNRM");
        open_rmc();
        put_text(",1,A,1.5,N,2..5,E");
        close_rmc(SUM_GOOD);
        open_rmc();
        put_text(",,A,7777,N,7777,E");
        close_rmc(SUM_GOOD);
        put_noise(5);
        send_packet();

        // nul as the status letter, top-bit byte in the body
        open_rmc();
        put_text(",1,");
        pkt_q.push_back(8'h00);
        put_text(",12,N,");
        pkt_q.push_back(8'hFF);
        close_rmc(SUM_GOOD);
        send_packet();

        // every kind of broken or odd checksum
        for (int t = SUM_WRONG; t <= SUM_CR_IN_BODY; t++)
        begin
            open_rmc();
            put_text(",,A,5555.5,N,6666.6,E");
            close_rmc(sum_tail_t'(t));
            send_packet();
        end

        // field count runs past its top
        open_rmc();
        put_text(",1,A,12.34,N,56.78,E");
        repeat (20) pkt_q.push_back(nrmc_pkg::CH_COMMA);
        put_text("9");
        close_rmc(SUM_GOOD);
        send_packet();

        // other talker only
        put_text("$GPRMC,1,A,1234.5,N,1,E*00\r\n");
        send_packet();

        // random packets
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            build_random_packet();
            send_packet();
        end
        in_valid <= 1'b0;

        // drain outstanding reports, then allow for the pipeline
        @(negedge clk);
        while (reports_waiting != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && reports_waiting == 0)
            $display("[nmea_rmc_position_parser] OK");
        else
            $display("[nmea_rmc_position_parser] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("[nmea_rmc_position_parser] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
